// ===== src/ppf_pkg.sv =====
// Shared types, constants and helpers for the polygon prism point filter.
// No dependencies; every other file of the block imports this package.
package ppf_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int OUTER_OFFSET     = 10240;

    localparam int COORD_W  = 32;
    localparam int COLOR_W  = 8;
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int OPW      = 35;          // operand width of the cross products
    localparam int PRODW    = 2 * OPW;     // width of one product
    localparam int STEP_W   = 4;
    localparam int NUM_STEPS = 10;         // five sums of two products per edge
    localparam int NUM_SIGNS = 5;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEST   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 2'd1;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_STEPS - 1);

    // commands from the controller to the datapath
    typedef struct packed {
        logic                pt_load;
        logic                append_en;
        logic                clear_en;
        logic                setup_load;
        logic                parity_clr;
        logic                rd_en;
        logic                prev_load;
        logic                diff_load;
        logic                mul_en;
        logic [STEP_W-1:0]   step;
        logic                edge_done;
        logic                out_load;
    } ppf_ctl_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic pass_ok;
        logic parity;
        logic out_busy;
    } ppf_sts_t;

    function automatic logic signed [OPW-1:0] sx_op(input logic [COORD_W-1:0] v);
        sx_op = $signed({{(OPW-COORD_W){v[COORD_W-1]}}, v});
    endfunction

endpackage

// ===== src/polygon_prism_point_filter.sv =====
// Polygon prism point filter, top level: ties the controller to the datapath.
// Depends on ppf_pkg, ppf_ctrl, ppf_rdaddr and ppf_datapath.
//
// Clear and append items complete without leaving the idle state.
// A test item walks the stored ring one edge at a time through a single
// 35x35 multiplier: five exact cross-product signs per edge, two products
// each. A point that passes the box and height check moves through S_CHECK
// and S_FIRST, walks its edges, settles the parity in S_FINISH and, when it
// is kept, hands over the result in S_OUT (waiting there while the output
// register is still held by out_ready); a point that fails the box or
// height check returns to idle from S_CHECK. The result sits in an output
// register, so one finished point may wait on out_ready while the block is
// idle again. Configuration writes are always taken.
module polygon_prism_point_filter #(
    parameter int MAX_VERTICES = ppf_pkg::MAX_VERTICES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ppf_pkg::CMD_W-1:0]           cmd,
    input  logic [ppf_pkg::COORD_W-1:0]         coord_x,
    input  logic [ppf_pkg::COORD_W-1:0]         coord_y,
    input  logic [ppf_pkg::COORD_W-1:0]         coord_z,
    input  logic [ppf_pkg::COLOR_W-1:0]         red,
    input  logic [ppf_pkg::COLOR_W-1:0]         green,
    input  logic [ppf_pkg::COLOR_W-1:0]         blue,
    input  logic                                colors_present,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ppf_pkg::COORD_W-1:0]         out_x,
    output logic [ppf_pkg::COORD_W-1:0]         out_y,
    output logic [ppf_pkg::COORD_W-1:0]         out_z,
    output logic [ppf_pkg::COLOR_W-1:0]         out_red,
    output logic [ppf_pkg::COLOR_W-1:0]         out_green,
    output logic [ppf_pkg::COLOR_W-1:0]         out_blue,
    output logic                                out_colors_valid,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ppf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ppf_pkg::COORD_W-1:0]         cfg_data
);
    import ppf_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);

    ppf_ctl_t      ctl;
    ppf_sts_t      sts;
    logic [CW-1:0] vcount;
    logic [AW-1:0] rd_addr;

    // register writes never stall
    assign cfg_ready = 1'b1;

    ppf_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sts      (sts),
        .vcount   (vcount),
        .ctl      (ctl)
    );

    // advance the read pointer with each edge read, restart it per point
    ppf_rdaddr #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_rdaddr (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (ctl.rd_en),
        .restart (ctl.setup_load),
        .addr    (rd_addr)
    );

    ppf_datapath #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .rd_addr          (rd_addr),
        .sts              (sts),
        .vcount           (vcount),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .coord_z          (coord_z),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .colors_present   (colors_present),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_x            (out_x),
        .out_y            (out_y),
        .out_z            (out_z),
        .out_red          (out_red),
        .out_green        (out_green),
        .out_blue         (out_blue),
        .out_colors_valid (out_colors_valid)
    );

endmodule

// ===== src/ppf_datapath.sv =====
// Datapath of the polygon prism point filter: vertex memory, bounding box,
// height registers, shared cross-product multiplier and the result register.
// Depends on ppf_pkg.
module ppf_datapath #(
    parameter int MAX_VERTICES = ppf_pkg::MAX_VERTICES_DEF,
    localparam int AW = $clog2(MAX_VERTICES),
    localparam int CW = $clog2(MAX_VERTICES + 1)
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ppf_pkg::ppf_ctl_t                       ctl,
    input  logic [AW-1:0]                           rd_addr,
    output ppf_pkg::ppf_sts_t                       sts,
    output logic [CW-1:0]                           vcount,
    input  logic [ppf_pkg::COORD_W-1:0]             coord_x,
    input  logic [ppf_pkg::COORD_W-1:0]             coord_y,
    input  logic [ppf_pkg::COORD_W-1:0]             coord_z,
    input  logic [ppf_pkg::COLOR_W-1:0]             red,
    input  logic [ppf_pkg::COLOR_W-1:0]             green,
    input  logic [ppf_pkg::COLOR_W-1:0]             blue,
    input  logic                                    colors_present,
    input  logic                                    cfg_valid,
    input  logic [ppf_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [ppf_pkg::COORD_W-1:0]             cfg_data,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [ppf_pkg::COORD_W-1:0]             out_x,
    output logic [ppf_pkg::COORD_W-1:0]             out_y,
    output logic [ppf_pkg::COORD_W-1:0]             out_z,
    output logic [ppf_pkg::COLOR_W-1:0]             out_red,
    output logic [ppf_pkg::COLOR_W-1:0]             out_green,
    output logic [ppf_pkg::COLOR_W-1:0]             out_blue,
    output logic                                    out_colors_valid
);
    import ppf_pkg::*;

    logic [2*COORD_W-1:0] mem [MAX_VERTICES];
    logic [2*COORD_W-1:0] rd_data_reg;

    logic [CW-1:0] count_reg;
    logic signed [COORD_W-1:0] last_x_reg, last_y_reg;
    logic signed [COORD_W-1:0] bmin_x_reg, bmin_y_reg, bmax_x_reg, bmax_y_reg;
    logic signed [COORD_W-1:0] min_h_reg, max_h_reg;

    logic signed [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [COLOR_W-1:0] pr_reg, pg_reg, pb_reg;
    logic pc_reg;

    logic signed [OPW-1:0] ox_reg, oy_reg, sa_reg, sb_reg, nsa_reg;
    logic signed [OPW-1:0] ox_c, oy_c;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [OPW-1:0] ea_reg, eb_reg;
    logic signed [OPW-1:0] d0_reg, d1_reg, d2_reg, d3_reg, d4_reg, d5_reg, d6_reg, d7_reg;
    logic signed [OPW-1:0] x1_c, y1_c, x2_c, y2_c;

    logic signed [OPW-1:0] op_a, op_b;
    logic signed [PRODW-1:0] prod_reg, acc_reg;
    logic [STEP_W-1:0] prod_step_reg;
    logic prod_vld_reg;
    logic signed [PRODW:0] sum_c;
    logic [NUM_SIGNS-1:0] pos_reg, neg_reg;
    logic parity_reg;
    logic hit_c;

    logic out_valid_reg;

    assign vcount = count_reg;

    // vertex memory: one write port for appends, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.append_en && (count_reg < CW'(MAX_VERTICES)))
        begin
            mem[count_reg[AW-1:0]] <= {coord_x, coord_y};
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            min_h_reg <= $signed({1'b1, {(COORD_W-1){1'b0}}});
            max_h_reg <= $signed({1'b0, {(COORD_W-1){1'b1}}});
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_MIN_HEIGHT))
            begin
                min_h_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == CFG_MAX_HEIGHT))
            begin
                max_h_reg <= cfg_data;
            end
            if (ctl.clear_en)
            begin
                count_reg <= '0;
            end
            else if (ctl.append_en && (count_reg < CW'(MAX_VERTICES)))
            begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // bounding box trails one vertex behind, so the closing vertex stays out
    always_ff @(posedge clk)
    begin
        if (ctl.append_en && (count_reg < CW'(MAX_VERTICES)))
        begin
            last_x_reg <= coord_x;
            last_y_reg <= coord_y;
            if (count_reg == '0)
            begin
                bmin_x_reg <= coord_x;
                bmax_x_reg <= coord_x;
                bmin_y_reg <= coord_y;
                bmax_y_reg <= coord_y;
            end
            else if (count_reg >= CW'(2))
            begin
                if (last_x_reg < bmin_x_reg) bmin_x_reg <= last_x_reg;
                if (last_y_reg < bmin_y_reg) bmin_y_reg <= last_y_reg;
                if (last_x_reg > bmax_x_reg) bmax_x_reg <= last_x_reg;
                if (last_y_reg > bmax_y_reg) bmax_y_reg <= last_y_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.pt_load)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
            pz_reg <= coord_z;
            pr_reg <= red;
            pg_reg <= green;
            pb_reg <= blue;
            pc_reg <= colors_present;
        end
    end

    assign ox_c = sx_op(bmin_x_reg) - OPW'(OUTER_OFFSET);
    assign oy_c = sx_op(bmin_y_reg) - OPW'(OUTER_OFFSET);

    assign sts.pass_ok = (px_reg > bmin_x_reg) && (px_reg < bmax_x_reg) &&
                         (py_reg > bmin_y_reg) && (py_reg < bmax_y_reg) &&
                         (pz_reg >= min_h_reg) && (pz_reg <= max_h_reg);

    always_ff @(posedge clk)
    begin
        if (ctl.setup_load)
        begin
            ox_reg  <= ox_c;
            oy_reg  <= oy_c;
            sa_reg  <= sx_op(py_reg) - oy_c;
            nsa_reg <= oy_c - sx_op(py_reg);
            sb_reg  <= ox_c - sx_op(px_reg);
        end
        if (ctl.prev_load)
        begin
            prev_x_reg <= rd_data_reg[2*COORD_W-1:COORD_W];
            prev_y_reg <= rd_data_reg[COORD_W-1:0];
        end
    end

    assign x1_c = sx_op(prev_x_reg);
    assign y1_c = sx_op(prev_y_reg);
    assign x2_c = sx_op(rd_data_reg[2*COORD_W-1:COORD_W]);
    assign y2_c = sx_op(rd_data_reg[COORD_W-1:0]);

    // per-edge differences, registered ahead of the multiplier
    always_ff @(posedge clk)
    begin
        if (ctl.diff_load)
        begin
            ea_reg <= y2_c - y1_c;
            eb_reg <= x1_c - x2_c;
            d0_reg <= ox_reg - x1_c;
            d1_reg <= oy_reg - y1_c;
            d2_reg <= sx_op(px_reg) - x1_c;
            d3_reg <= sx_op(py_reg) - y1_c;
            d4_reg <= x1_c - ox_reg;
            d5_reg <= y1_c - oy_reg;
            d6_reg <= x2_c - ox_reg;
            d7_reg <= y2_c - oy_reg;
        end
    end

    always_comb
    begin
        case (ctl.step)
            4'd0:    begin op_a = ea_reg;  op_b = d0_reg; end
            4'd1:    begin op_a = eb_reg;  op_b = d1_reg; end
            4'd2:    begin op_a = ea_reg;  op_b = d2_reg; end
            4'd3:    begin op_a = eb_reg;  op_b = d3_reg; end
            4'd4:    begin op_a = sa_reg;  op_b = d4_reg; end
            4'd5:    begin op_a = sb_reg;  op_b = d5_reg; end
            4'd6:    begin op_a = sa_reg;  op_b = d6_reg; end
            4'd7:    begin op_a = sb_reg;  op_b = d7_reg; end
            4'd8:    begin op_a = ea_reg;  op_b = sb_reg; end
            4'd9:    begin op_a = nsa_reg; op_b = eb_reg; end
            default: begin op_a = '0;      op_b = '0;     end
        endcase
    end

    assign sum_c = $signed({acc_reg[PRODW-1], acc_reg}) +
                   $signed({prod_reg[PRODW-1], prod_reg});

    always_ff @(posedge clk)
    begin
        prod_reg      <= op_a * op_b;
        prod_step_reg <= ctl.step;
        if (prod_vld_reg)
        begin
            if (!prod_step_reg[0])
            begin
                acc_reg <= prod_reg;
            end
            else
            begin
                pos_reg[prod_step_reg[3:1]] <= !sum_c[PRODW] && (sum_c != '0);
                neg_reg[prod_step_reg[3:1]] <= sum_c[PRODW];
            end
        end
    end

    assign hit_c = !((pos_reg[0] && pos_reg[1]) || (neg_reg[0] && neg_reg[1])) &&
                   !((pos_reg[2] && pos_reg[3]) || (neg_reg[2] && neg_reg[3])) &&
                   (pos_reg[4] || neg_reg[4]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg  <= 1'b0;
            parity_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= ctl.mul_en;
            if (ctl.parity_clr)
            begin
                parity_reg <= 1'b0;
            end
            else if (ctl.edge_done)
            begin
                parity_reg <= parity_reg ^ hit_c;
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            out_x            <= px_reg;
            out_y            <= py_reg;
            out_z            <= pz_reg;
            out_red          <= pc_reg ? pr_reg : '0;
            out_green        <= pc_reg ? pg_reg : '0;
            out_blue         <= pc_reg ? pb_reg : '0;
            out_colors_valid <= pc_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sts.parity   = parity_reg;
    assign sts.out_busy = out_valid_reg && !out_ready;

endmodule

// ===== src/ppf_ctrl.sv =====
// Controller of the polygon prism point filter: accepts items and sequences
// the edge walk and multiplier steps of a tested point. Depends on ppf_pkg.
module ppf_ctrl #(
    parameter int MAX_VERTICES = ppf_pkg::MAX_VERTICES_DEF,
    localparam int CW = $clog2(MAX_VERTICES + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ppf_pkg::CMD_W-1:0]   cmd,
    input  ppf_pkg::ppf_sts_t           sts,
    input  logic [CW-1:0]               vcount,
    output ppf_pkg::ppf_ctl_t           ctl
);
    import ppf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_FIRST  = 9'b000000100,
        S_DIFF   = 9'b000001000,
        S_MUL    = 9'b000010000,
        S_DRAIN  = 9'b000100000,
        S_EDGE   = 9'b001000000,
        S_FINISH = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        ctl        = '0;
        ctl.step   = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                ctl.pt_load   = accept;
                ctl.append_en = accept && (cmd == CMD_APPEND);
                ctl.clear_en  = accept && (cmd == CMD_CLEAR);
                if (accept && (cmd == CMD_TEST) && (vcount != '0))
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.setup_load = 1'b1;
                ctl.parity_clr = 1'b1;
                ctl.rd_en      = 1'b1;
                idx_next       = '0;
                state_next     = sts.pass_ok ? S_FIRST : S_IDLE;
            end
            S_FIRST:
            begin
                ctl.prev_load = 1'b1;
                if (vcount > CW'(1))
                begin
                    idx_next   = CW'(1);
                    state_next = S_DIFF;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIFF:
            begin
                ctl.diff_load = 1'b1;
                step_next     = '0;
                state_next    = S_MUL;
            end
            S_MUL:
            begin
                ctl.mul_en = 1'b1;
                step_next  = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                ctl.edge_done = 1'b1;
                ctl.prev_load = 1'b1;
                if ((idx_reg + 1'b1) < vcount)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DIFF;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = sts.parity ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // the read port follows the index chosen for the next edge
        if (state_reg == S_FIRST || state_reg == S_EDGE)
        begin
            ctl.rd_en = (state_next == S_DIFF);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== src/ppf_rdaddr.sv =====
// Read address select for the vertex memory: the index register, zero
// when a point restarts the walk, or the index about to be taken when
// the controller moves to the next edge. Depends on ppf_pkg.
module ppf_rdaddr #(
    parameter int MAX_VERTICES = ppf_pkg::MAX_VERTICES_DEF,
    localparam int AW = $clog2(MAX_VERTICES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          restart,
    output logic [AW-1:0] addr
);
    import ppf_pkg::*;

    logic [AW-1:0] addr_reg, addr_next;

    always_comb
    begin
        addr_next = addr_reg;
        if (restart)
        begin
            addr_next = '0;
        end
        else if (adv)
        begin
            addr_next = addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else
        begin
            addr_reg <= addr_next;
        end
    end

    assign addr = addr_next;

endmodule

// ===== tb/sv/tb_polygon_prism_point_filter.sv =====
// Self-checking testbench for the polygon prism point filter.
// Depends on ppf_pkg and polygon_prism_point_filter; carries its own ring predictor.
module tb_polygon_prism_point_filter;
    import ppf_pkg::*;

    // A test point can walk every edge of a full store; allow margin on top.
    localparam int DRAIN_CYCLES = 1000;
    localparam int STALL_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 3000;
    localparam int PHASE_ITEMS  = 350;
    localparam int NUM_PHASES   = 5;

    // command code the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]   cmd;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic               cp;
    } point_item_t;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COLOR_W-1:0] r;
        logic [COLOR_W-1:0] g;
        logic [COLOR_W-1:0] b;
        logic               cv;
    } kept_point_t;

    // Directed row: fixed rows carry a typed-in outcome instead of a prediction.
    typedef struct {
        point_item_t it;
        bit          fixed;
        bit          keeps;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [CMD_W-1:0]     cmd;
    logic [COORD_W-1:0]   coord_x;
    logic [COORD_W-1:0]   coord_y;
    logic [COORD_W-1:0]   coord_z;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
    logic                 colors_present;
    logic                 out_valid;
    logic                 out_ready;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;
    logic [COORD_W-1:0]   out_z;
    logic [COLOR_W-1:0]   out_red;
    logic [COLOR_W-1:0]   out_green;
    logic [COLOR_W-1:0]   out_blue;
    logic                 out_colors_valid;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    polygon_prism_point_filter u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .cmd              (cmd),
        .coord_x          (coord_x),
        .coord_y          (coord_y),
        .coord_z          (coord_z),
        .red              (red),
        .green            (green),
        .blue             (blue),
        .colors_present   (colors_present),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_x            (out_x),
        .out_y            (out_y),
        .out_z            (out_z),
        .out_red          (out_red),
        .out_green        (out_green),
        .out_blue         (out_blue),
        .out_colors_valid (out_colors_valid),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Predictor state: the ring, its box and the height window.
    longint      ring_x [MAX_VERTICES_DEF];
    longint      ring_y [MAX_VERTICES_DEF];
    int          ring_len;
    longint      bx_lo, by_lo, bx_hi, by_hi;
    longint      z_lo, z_hi;

    kept_point_t kept_q [$];
    dir_row_t    dir_rows [$];
    int          errors;
    int          accepted;
    int          idle_run;
    bit          no_idle;
    bit          hold_req;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Sign of a*b + c*d, exact in 128 bits.
    function automatic int cross_sign(longint a, longint b, longint c, longint d);
        logic signed [127:0] wa, wb, wc, wd, p;
        wa = a;
        wb = b;
        wc = c;
        wd = d;
        p  = wa * wb + wc * wd;
        return (p < 0) ? -1 : ((p == 0) ? 0 : 1);
    endfunction

    // Count an edge when neither side test separates strictly and the lines
    // are not parallel; touching counts as a crossing.
    function automatic bit edge_crossed(longint x1, longint y1, longint x2, longint y2,
                                        longint qx1, longint qy1, longint qx2, longint qy2);
        longint ea, eb, sa, sb;
        ea = y2 - y1;
        eb = x1 - x2;
        sa = qy2 - qy1;
        sb = qx1 - qx2;
        if (cross_sign(ea, qx1 - x1, eb, qy1 - y1) * cross_sign(ea, qx2 - x1, eb, qy2 - y1) > 0)
            return 1'b0;
        if (cross_sign(sa, x1 - qx1, sb, y1 - qy1) * cross_sign(sa, x2 - qx1, sb, y2 - qy1) > 0)
            return 1'b0;
        return cross_sign(ea, sb, -sa, eb) != 0;
    endfunction

    function automatic kept_point_t echo_of(point_item_t it);
        kept_point_t k;
        k.x  = it.x;
        k.y  = it.y;
        k.z  = it.z;
        k.r  = it.cp ? it.r : '0;
        k.g  = it.cp ? it.g : '0;
        k.b  = it.cp ? it.b : '0;
        k.cv = it.cp;
        return k;
    endfunction

    // Advance the ring state by one item; queue the kept point if any.
    task automatic filter_point(point_item_t it);
        longint px, py, pz, ox, oy;
        int     hits;
        px = $signed(it.x);
        py = $signed(it.y);
        pz = $signed(it.z);
        if (it.cmd == CMD_CLEAR)
            ring_len = 0;
        else if (it.cmd == CMD_APPEND)
        begin
            if (ring_len < MAX_VERTICES_DEF)
            begin
                ring_x[ring_len] = px;
                ring_y[ring_len] = py;
                if (ring_len == 0)
                begin
                    bx_lo = px; bx_hi = px;
                    by_lo = py; by_hi = py;
                end
                else if (ring_len >= 2)
                begin
                    // the box lags one vertex so the closing repeat is left out
                    if (ring_x[ring_len-1] < bx_lo) bx_lo = ring_x[ring_len-1];
                    if (ring_y[ring_len-1] < by_lo) by_lo = ring_y[ring_len-1];
                    if (ring_x[ring_len-1] > bx_hi) bx_hi = ring_x[ring_len-1];
                    if (ring_y[ring_len-1] > by_hi) by_hi = ring_y[ring_len-1];
                end
                ring_len++;
            end
        end
        else if (it.cmd == CMD_TEST && ring_len > 0 && px > bx_lo && px < bx_hi &&
                 py > by_lo && py < by_hi && pz >= z_lo && pz <= z_hi)
        begin
            ox = bx_lo - OUTER_OFFSET;
            oy = by_lo - OUTER_OFFSET;
            hits = 0;
            for (int i = 1; i < ring_len; i++)
                hits += edge_crossed(ring_x[i-1], ring_y[i-1], ring_x[i], ring_y[i],
                                     ox, oy, px, py);
            if (hits % 2 == 1)
                kept_q = {kept_q, echo_of(it)};
        end
    endtask

    function automatic point_item_t rand_item();
        point_item_t it;
        it.cmd = CMD_W'($urandom);
        it.x   = $urandom;
        it.y   = $urandom;
        it.z   = $urandom;
        it.r   = COLOR_W'($urandom);
        it.g   = COLOR_W'($urandom);
        it.b   = COLOR_W'($urandom);
        it.cp  = 1'($urandom);
        return it;
    endfunction

    function automatic dir_row_t row(logic [CMD_W-1:0] c, longint x, longint y, longint z,
                                     bit fixed, bit keeps);
        dir_row_t d;
        d.it     = '{c, COORD_W'(x), COORD_W'(y), COORD_W'(z), 8'hff, 8'h00, 8'ha5, 1'b1};
        d.fixed  = fixed;
        d.keeps  = keeps;
        return d;
    endfunction

    // Append one row to the directed table.
    task automatic add_row(logic [CMD_W-1:0] c, longint x, longint y, longint z,
                           bit fixed, bit keeps);
        dir_rows = {dir_rows, row(c, x, y, z, fixed, keeps)};
    endtask

    // Offer one item; idle at random first, then hold it until transfer.
    task automatic offer(point_item_t it, bit fixed = 1'b0, bit keeps = 1'b0);
        while (!no_idle && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        cmd            <= it.cmd;
        coord_x        <= it.x;
        coord_y        <= it.y;
        coord_z        <= it.z;
        red            <= it.r;
        green          <= it.g;
        blue           <= it.b;
        colors_present <= it.cp;
        do
            @(posedge clk);
        while (!in_ready);
        accepted++;
        if (!fixed)
            filter_point(it);
        else if (keeps)
            kept_q = {kept_q, echo_of(it)};
    endtask

    // Build a simple star-shaped ring around a random center, closed on
    // its first vertex; wild rings take full-range vertices instead.
    task automatic offer_ring(int n, longint half, bit wild);
        point_item_t it;
        longint cx, cy, t, f, px, py, fx, fy;
        cx = longint'($urandom_range(2097152)) - 1048576;
        cy = longint'($urandom_range(2097152)) - 1048576;
        it = rand_item();
        it.cmd = CMD_CLEAR;
        offer(it);
        for (int k = 0; k < n; k++)
        begin
            t = k * 4000 / n + $urandom_range(4000 / n - 1);
            f = (t % 1000) * 2 * half / 1000;
            case (t / 1000)
                0: begin px = cx - half + f; py = cy - half;     end
                1: begin px = cx + half;     py = cy - half + f; end
                2: begin px = cx + half - f; py = cy + half;     end
                default: begin px = cx - half; py = cy + half - f; end
            endcase
            if (wild)
            begin
                px = $signed($urandom);
                py = $signed($urandom);
            end
            if (k == 0)
            begin
                fx = px;
                fy = py;
            end
            it = rand_item();
            it.cmd = CMD_APPEND;
            it.x = COORD_W'(px);
            it.y = COORD_W'(py);
            offer(it);
        end
        it = rand_item();
        it.cmd = CMD_APPEND;
        it.x = COORD_W'(fx);
        it.y = COORD_W'(fy);
        offer(it);
    endtask

    // Test points spread over the box, its rim included.
    task automatic offer_points(int m);
        point_item_t it;
        longint w;
        for (int k = 0; k < m; k++)
        begin
            it = rand_item();
            it.cmd = CMD_TEST;
            w = bx_hi - bx_lo + 3;
            it.x = COORD_W'(bx_lo - 1 + longint'({$urandom, $urandom} >> 1) % w);
            w = by_hi - by_lo + 3;
            it.y = COORD_W'(by_lo - 1 + longint'({$urandom, $urandom} >> 1) % w);
            if ($urandom_range(99) < 80)
                it.z = COORD_W'(longint'($urandom_range(8000)) - 4000);
            offer(it);
        end
    endtask

    // Write both height registers once nothing is in flight.
    task automatic set_heights(longint lo, longint hi);
        // drop the last offered item so it is not taken twice
        in_valid <= 1'b0;
        while (kept_q.size() > 0)
            @(posedge clk);
        // a point that keeps nothing may still be walking its ring
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MIN_HEIGHT;
        cfg_data  <= COORD_W'(lo);
        do
            @(posedge clk);
        while (!cfg_ready);
        z_lo = lo;
        cfg_index <= CFG_MAX_HEIGHT;
        cfg_data  <= COORD_W'(hi);
        do
            @(posedge clk);
        while (!cfg_ready);
        z_hi = hi;
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // Receiver: random backpressure, or one long hold-off when asked.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= no_idle || ($urandom_range(99) >= 19);
        end
    end

    // Compare every result transfer with the oldest kept point.
    initial
    begin
        kept_point_t k;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (kept_q.size() == 0)
                begin
                    $error("unexpected result x=%0h y=%0h", out_x, out_y);
                    errors++;
                end
                else
                begin
                    k = kept_q.pop_front();
                    check_field("out_x", k.x, out_x);
                    check_field("out_y", k.y, out_y);
                    check_field("out_z", k.z, out_z);
                    check_field("out_red", k.r, out_red);
                    check_field("out_green", k.g, out_green);
                    check_field("out_blue", k.b, out_blue);
                    check_field("out_colors_valid", k.cv, out_colors_valid);
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    initial
    begin
        idle_run = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_run = 0;
            else if (++idle_run >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        longint lo, hi;
        int     pick;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        cmd            = CMD_CLEAR;
        coord_x        = '0;
        coord_y        = '0;
        coord_z        = '0;
        red            = '0;
        green          = '0;
        blue           = '0;
        colors_present = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_MIN_HEIGHT;
        cfg_data       = '0;
        errors         = 0;
        accepted       = 0;
        no_idle        = 1'b0;
        hold_req       = 1'b0;
        ring_len       = 0;
        bx_lo = 0; by_lo = 0; bx_hi = 0; by_hi = 0;
        z_lo  = -64'sd2147483648;
        z_hi  = 64'sd2147483647;

        // Directed rows: empty ring, single vertex, square with colors on and
        // off, rim and height extremes, unused command, full-range ring.
        add_row(CMD_TEST, 0, 0, 0, 1, 0);
        add_row(CMD_CLEAR, 0, 0, 0, 0, 0);
        add_row(CMD_APPEND, 0, 0, 0, 0, 0);
        add_row(CMD_TEST, 0, 0, 0, 1, 0);
        add_row(CMD_CLEAR, 0, 0, 0, 0, 0);
        add_row(CMD_APPEND, -1000, -1000, 0, 0, 0);
        add_row(CMD_APPEND, 1000, -1000, 0, 0, 0);
        add_row(CMD_APPEND, 1000, 1000, 0, 0, 0);
        add_row(CMD_APPEND, -1000, 1000, 0, 0, 0);
        add_row(CMD_APPEND, -1000, -1000, 0, 0, 0);
        add_row(CMD_TEST, 0, 0, 0, 0, 0);
        add_row(CMD_TEST, 500, -500, 0, 0, 0);
        add_row(CMD_TEST, -500, 500, 0, 0, 0);
        add_row(CMD_TEST, 1000, 0, 0, 1, 0);
        add_row(CMD_TEST, 0, -1000, 0, 1, 0);
        add_row(CMD_TEST, 999, 999, -64'sd2147483648, 0, 0);
        add_row(CMD_TEST, -999, -999, 64'sd2147483647, 0, 0);
        add_row(CMD_UNUSED, 0, 0, 0, 1, 0);
        add_row(CMD_CLEAR, 0, 0, 0, 0, 0);
        add_row(CMD_APPEND, -64'sd2147483648, -64'sd2147483648, 0, 0, 0);
        add_row(CMD_APPEND, 64'sd2147483647, -64'sd2147483648, 0, 0, 0);
        add_row(CMD_APPEND, 0, 64'sd2147483647, 0, 0, 0);
        add_row(CMD_APPEND, -64'sd2147483648, -64'sd2147483648, 0, 0, 0);
        add_row(CMD_TEST, 0, 0, 7, 0, 0);
        add_row(CMD_TEST, 1, -64'sd2147483640, 7, 0, 0);
        add_row(CMD_TEST, 64'sd2147483646, -64'sd2147483647, 0, 0, 0);
        // drop the colors on one kept point
        dir_rows[12].it.cp = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer(dir_rows[i].it, dir_rows[i].fixed, dir_rows[i].keeps);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
                1: begin lo = -1000; hi = 1000; end
                2: begin lo = 0; hi = 0; end
                3: begin lo = 64'sd2147483647; hi = -64'sd2147483648; end
                default: begin
                    lo = longint'($urandom_range(4000)) - 4000;
                    hi = longint'($urandom_range(4000));
                end
            endcase
            set_heights(lo, hi);
            // advance through one stretch with no idling on either side
            no_idle = (ph == 3);
            // overfill the store once per phase
            offer_ring(70, 500000, 1'b0);
            offer_points(2);
            if (ph == 1)
                hold_req = 1'b1;
            while (accepted < dir_rows.size() + PHASE_ITEMS * (ph + 1))
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    offer_ring($urandom_range(8, 3), $urandom_range(200000, 50), 1'b0);
                    offer_points($urandom_range(10, 3));
                end
                else if (pick < 80)
                begin
                    offer_ring($urandom_range(6, 3), 1000, 1'b1);
                    offer_points(3);
                end
                else
                    offer(rand_item());
                // late in phase 2, pause the sender until the block has drained whenever results are pending
                if (ph == 2 && accepted > dir_rows.size() + PHASE_ITEMS * 2 + 100 &&
                    kept_q.size() > 0)
                begin
                    in_valid <= 1'b0;
                    while (kept_q.size() > 0)
                        @(posedge clk);
                end
            end
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        while (kept_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== polygon_prism_point_filter.f =====
src/ppf_pkg.sv
src/ppf_datapath.sv
src/ppf_ctrl.sv
src/ppf_rdaddr.sv
src/polygon_prism_point_filter.sv
tb/sv/tb_polygon_prism_point_filter.sv
